/* sv/track_segment_matcher_unit_macros.svh */
// Assertion macros for the track segment matcher.
// No dependencies; expects i_clk and i_rst_n in the including scope.
`ifndef TRACK_SEGMENT_MATCHER_UNIT_MACROS_SVH
`define TRACK_SEGMENT_MATCHER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/tsm_pkg.sv */
// Package for the track segment matcher: widths, register indexes,
// cut limits and the segment position tables. No dependencies.
package tsm_pkg;

    localparam int SEG_W    = 5;
    localparam int OSEG_W   = 6;
    localparam int EN_W     = 16;
    localparam int TIME_W   = 16;
    localparam int CFG_W    = 32;
    localparam int CIDX_W   = 3;
    localparam int POS_W    = 13;   // segment centers fit in +-4095 (1/16 mm)
    localparam int COORD_W  = 16;

    localparam int CALO_SEGMENTS = 24;
    localparam int PION_SEGMENTS = 32;

    localparam logic signed [TIME_W-1:0] TIME_WINDOW = 16'sd800;
    localparam logic [9:0] CALO_LIMIT = 10'd400;
    localparam logic [9:0] PION_LIMIT = 10'd640;

    localparam logic signed [OSEG_W-1:0] SEG_NONE = -6'sd1;
    localparam logic [CFG_W-1:0] NORM_RESET = 32'd65536;

    localparam logic DET_CALO = 1'b0;
    localparam logic DET_PION = 1'b1;

    typedef enum logic [CIDX_W-1:0] {
        REG_AXIS_SWAP = 3'd0,
        REG_SLOPE     = 3'd1,
        REG_INTERCEPT = 3'd2,
        REG_NORM      = 3'd3,
        REG_ORIGIN_X  = 3'd4,
        REG_ORIGIN_Y  = 3'd5,
        REG_DIR_U     = 3'd6,
        REG_DIR_V     = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } t_pos;

    localparam logic signed [POS_W-1:0] CALO_X [32] = '{
        13'sd1800, 13'sd1800, 13'sd1959, 13'sd1442, 13'sd1103, 13'sd811,
        13'sd240, -13'sd240, -13'sd811, -13'sd1103, -13'sd1442, -13'sd1959,
        -13'sd1800, -13'sd1800, -13'sd1959, -13'sd1442, -13'sd1103, -13'sd811,
        -13'sd240, 13'sd240, 13'sd811, 13'sd1103, 13'sd1442, 13'sd1959,
        13'sd0, 13'sd0, 13'sd1959, 13'sd0, 13'sd0, 13'sd811, 13'sd0, 13'sd0
    };
    localparam logic signed [POS_W-1:0] CALO_Y [32] = '{
        -13'sd240, 13'sd240, 13'sd811, 13'sd1103, 13'sd1442, 13'sd1959,
        13'sd1800, 13'sd1800, 13'sd1959, 13'sd1442, 13'sd1103, 13'sd811,
        13'sd240, -13'sd240, -13'sd811, -13'sd1103, -13'sd1442, -13'sd1959,
        -13'sd1800, -13'sd1800, -13'sd1959, -13'sd1442, -13'sd1103, -13'sd811,
        13'sd0, 13'sd0, 13'sd811, 13'sd0, 13'sd0, 13'sd1959, 13'sd0, 13'sd0
    };
    localparam logic signed [POS_W-1:0] PION_X [32] = '{
        13'sd2664, 13'sd2664, 13'sd2664, 13'sd2537, 13'sd2223, 13'sd1884,
        13'sd1544, 13'sd1051, 13'sd480, 13'sd0, -13'sd480, -13'sd1051,
        -13'sd1544, -13'sd1884, -13'sd2223, -13'sd2537, -13'sd2664, -13'sd2664,
        -13'sd2664, -13'sd2537, -13'sd2223, -13'sd1884, -13'sd1544, -13'sd1051,
        -13'sd480, 13'sd0, 13'sd480, 13'sd1051, 13'sd1544, 13'sd1884,
        13'sd2223, 13'sd2537
    };
    localparam logic signed [POS_W-1:0] PION_Y [32] = '{
        -13'sd480, 13'sd0, 13'sd480, 13'sd1051, 13'sd1544, 13'sd1884,
        13'sd2223, 13'sd2537, 13'sd2664, 13'sd2664, 13'sd2664, 13'sd2537,
        13'sd2223, 13'sd1884, 13'sd1544, 13'sd1051, 13'sd480, 13'sd0,
        -13'sd480, -13'sd1051, -13'sd1544, -13'sd1884, -13'sd2223, -13'sd2537,
        -13'sd2664, -13'sd2664, -13'sd2664, -13'sd2537, -13'sd2223, -13'sd1884,
        -13'sd1544, -13'sd1051
    };

    // Segment center; segments past the detector's count sit at the origin.
    function automatic t_pos seg_pos(input logic det, input logic [SEG_W-1:0] seg);
        t_pos p;
        p.x = '0;
        p.y = '0;
        if (det == DET_PION) begin
            if (int'(seg) < PION_SEGMENTS) begin
                p.x = PION_X[seg];
                p.y = PION_Y[seg];
            end
        end else begin
            if (int'(seg) < CALO_SEGMENTS) begin
                p.x = CALO_X[seg];
                p.y = CALO_Y[seg];
            end
        end
        return p;
    endfunction

endpackage

/* sv/track_segment_matcher_unit.sv */
// Track segment matcher: time window, direction and line-distance cuts per hit.
// Uses tsm_pkg and track_segment_matcher_unit_macros.svh.
// A hit's final sample goes through stage A, stage B and the output register.
// One sample per cycle unless o_stall; only a hit's final sample yields a result.
// Stages: input register, ROM + multiplies, compare + state update into output reg.
// Reset (i_rst_n low, synchronous) resets valids, track state and config regs.
`include "track_segment_matcher_unit_macros.svh"

module track_segment_matcher_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_detector,
    input  logic [tsm_pkg::SEG_W-1:0]          i_segment,
    input  logic [tsm_pkg::EN_W-1:0]           i_energy,
    input  logic signed [tsm_pkg::TIME_W-1:0]  i_hit_time,
    input  logic                               i_last_of_hit,
    input  logic                               i_last_of_track,
    // result channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_matched,
    output logic signed [tsm_pkg::OSEG_W-1:0]  o_best_calo_segment,
    output logic signed [tsm_pkg::OSEG_W-1:0]  o_pion_id_segment,
    output logic                               o_track_done,
    // configuration
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tsm_pkg::CIDX_W-1:0]         i_cfg_index,
    input  logic [tsm_pkg::CFG_W-1:0]          i_cfg_data
);
    import tsm_pkg::*;

    localparam int PROD_W = CFG_W + POS_W;      // slope * coordinate
    localparam int NUM_W  = CFG_W + 16 + 1;     // intercept << 16 plus headroom
    localparam int DX_W   = COORD_W + 1;
    localparam int DOTP_W = COORD_W + DX_W;
    localparam int DOT_W  = DOTP_W + 1;
    localparam int LIM_W  = CFG_W + 10;

    // configuration registers
    logic                     r_axis_swap;
    logic signed [CFG_W-1:0]  r_slope;
    logic signed [CFG_W-1:0]  r_intercept;
    logic [CFG_W-1:0]         r_norm;
    logic signed [COORD_W-1:0] r_origin_x, r_origin_y, r_dir_u, r_dir_v;

    // track state
    logic                       r_time_seen;
    logic [EN_W-1:0]            r_best_energy;
    logic signed [OSEG_W-1:0]   r_best_calo;
    logic signed [OSEG_W-1:0]   r_last_pion;

    // stage A: accepted final samples
    logic                 r_a_v, r_a_det, r_a_in_time, r_a_last_trk;
    logic [SEG_W-1:0]     r_a_seg;
    logic [EN_W-1:0]      r_a_energy;

    // stage B: products
    logic                       r_b_v, r_b_det, r_b_in_time, r_b_last_trk, r_b_dir_zero;
    logic [SEG_W-1:0]           r_b_seg;
    logic [EN_W-1:0]            r_b_energy;
    logic signed [PROD_W-1:0]   r_b_prod;
    logic signed [POS_W-1:0]    r_b_q;
    logic signed [DOTP_W-1:0]   r_b_dot_u, r_b_dot_v;
    logic [LIM_W-1:0]           r_b_lim;

    // output register
    logic                       r_out_v, r_out_matched, r_out_done;
    logic signed [OSEG_W-1:0]   r_out_calo, r_out_pion;

    logic en_out, en_b, en_a, w_in_acc, w_in_time;

    assign en_out   = !r_out_v || !i_stall;
    assign en_b     = !r_b_v || en_out;
    assign en_a     = !r_a_v || en_b;
    assign o_stall  = !en_a;
    assign w_in_acc = i_valid && en_a;
    assign o_cfg_ready = 1'b1;

    assign w_in_time = r_time_seen ||
        ((i_hit_time > -TIME_WINDOW) && (i_hit_time < TIME_WINDOW));

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_swap <= 1'b0;
            r_slope     <= '0;
            r_intercept <= '0;
            r_norm      <= NORM_RESET;
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_dir_u     <= '0;
            r_dir_v     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_AXIS_SWAP: r_axis_swap <= i_cfg_data[0];
                REG_SLOPE:     r_slope     <= i_cfg_data;
                REG_INTERCEPT: r_intercept <= i_cfg_data;
                REG_NORM:      r_norm      <= i_cfg_data;
                REG_ORIGIN_X:  r_origin_x  <= i_cfg_data[COORD_W-1:0];
                REG_ORIGIN_Y:  r_origin_y  <= i_cfg_data[COORD_W-1:0];
                REG_DIR_U:     r_dir_u     <= i_cfg_data[COORD_W-1:0];
                REG_DIR_V:     r_dir_v     <= i_cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage A ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_seen <= 1'b0;
            r_a_v       <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_time_seen <= i_last_of_hit ? 1'b0 : w_in_time;
            end
            if (en_a) begin
                r_a_v <= w_in_acc && i_last_of_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_det      <= i_detector;
            r_a_seg      <= i_segment;
            r_a_energy   <= i_energy;
            r_a_in_time  <= w_in_time;
            r_a_last_trk <= i_last_of_track;
        end
    end

    // ---------------- stage B ----------------
    t_pos                     w_pos;
    logic signed [POS_W-1:0]  w_p, w_q;
    logic signed [DX_W-1:0]   w_dx, w_dy;
    logic [9:0]               w_limit;

    always_comb begin
        w_pos   = seg_pos(r_a_det, r_a_seg);
        w_p     = r_axis_swap ? w_pos.y : w_pos.x;
        w_q     = r_axis_swap ? w_pos.x : w_pos.y;
        w_dx    = DX_W'(w_pos.x) - DX_W'(r_origin_x);
        w_dy    = DX_W'(w_pos.y) - DX_W'(r_origin_y);
        w_limit = (r_a_det == DET_PION) ? PION_LIMIT : CALO_LIMIT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en_b) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_det      <= r_a_det;
            r_b_seg      <= r_a_seg;
            r_b_energy   <= r_a_energy;
            r_b_in_time  <= r_a_in_time;
            r_b_last_trk <= r_a_last_trk;
            r_b_dir_zero <= (r_dir_u == '0) && (r_dir_v == '0);
            r_b_prod     <= r_slope * w_p;
            r_b_q        <= w_q;
            r_b_dot_u    <= r_dir_u * w_dx;
            r_b_dot_v    <= r_dir_v * w_dy;
            r_b_lim      <= LIM_W'(w_limit) * LIM_W'(r_norm);
        end
    end

    // ---------------- stage C: cuts and track state ----------------
    logic signed [NUM_W-1:0]  w_num;
    logic [NUM_W-1:0]         w_mag;
    logic signed [DOT_W-1:0]  w_dot;
    logic                     w_near, w_match, w_better;
    logic [EN_W-1:0]          n_best_energy;
    logic signed [OSEG_W-1:0] n_best_calo, n_last_pion;

    always_comb begin
        w_num = NUM_W'(r_b_prod)
              - $signed({{(NUM_W-POS_W-16){r_b_q[POS_W-1]}}, r_b_q, 16'b0})
              + $signed({r_intercept[CFG_W-1], r_intercept, 16'b0});
        w_mag  = w_num[NUM_W-1] ? NUM_W'(-w_num) : NUM_W'(w_num);
        w_near = w_mag < NUM_W'(r_b_lim);
        w_dot  = DOT_W'(r_b_dot_u) + DOT_W'(r_b_dot_v);

        w_match = r_b_in_time && w_near && !w_dot[DOT_W-1] && !r_b_dir_zero &&
                  ((r_b_det == DET_PION) || (r_b_energy != '0));
        w_better = w_match && (r_b_det == DET_CALO) && (r_b_energy > r_best_energy);

        n_best_energy = w_better ? r_b_energy : r_best_energy;
        n_best_calo   = w_better ? $signed({1'b0, r_b_seg}) : r_best_calo;
        n_last_pion   = (w_match && (r_b_det == DET_PION)) ?
                        $signed({1'b0, r_b_seg}) : r_last_pion;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v       <= 1'b0;
            r_best_energy <= '0;
            r_best_calo   <= SEG_NONE;
            r_last_pion   <= SEG_NONE;
        end else if (en_out) begin
            r_out_v <= r_b_v;
            if (r_b_v) begin
                // a closing hit reports the updated values, then starts clean
                if (r_b_last_trk) begin
                    r_best_energy <= '0;
                    r_best_calo   <= SEG_NONE;
                    r_last_pion   <= SEG_NONE;
                end else begin
                    r_best_energy <= n_best_energy;
                    r_best_calo   <= n_best_calo;
                    r_last_pion   <= n_last_pion;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_matched <= w_match;
            r_out_calo    <= n_best_calo;
            r_out_pion    <= n_last_pion;
            r_out_done    <= r_b_last_trk;
        end
    end

    assign o_valid             = r_out_v;
    assign o_matched           = r_out_matched;
    assign o_best_calo_segment = r_out_calo;
    assign o_pion_id_segment   = r_out_pion;
    assign o_track_done        = r_out_done;

    // ---------------- assertions ----------------
    `TSM_ASSERT_NEXT(a_track_clear, (en_out && r_b_v && r_b_last_trk),
        (r_best_calo == SEG_NONE && r_last_pion == SEG_NONE && r_best_energy == '0),
        "track state not cleared after closing hit")
    `TSM_ASSERT_SAME(a_best_consistent, 1'b1,
        ((r_best_calo == SEG_NONE) == (r_best_energy == '0)),
        "best calorimeter segment and energy disagree")
    `TSM_ASSERT_NEXT(a_time_flag_clear, (w_in_acc && i_last_of_hit), (!r_time_seen),
        "time flag survived the end of a hit")

endmodule

/* tb/sv/track_segment_matcher_unit_tb.sv */
// Self-checking testbench for track_segment_matcher_unit: directed cut checks, then
// random tracks and hit streams scored against an in-bench track matcher.
// Depends on tsm_pkg and the track_segment_matcher_unit RTL.
module track_segment_matcher_unit_tb;
    import tsm_pkg::*;

    localparam int HIT_WINDOW  = 800;     // 50 ns in 1/16 ns
    localparam int CALO_REACH  = 400;     // 25 mm in 1/16 mm
    localparam int PION_REACH  = 640;     // 40 mm in 1/16 mm
    localparam int NUM_CALO    = 24;
    localparam int NUM_PION    = 32;
    localparam int TAIL_CYCLES = 8;
    localparam int RUN_LIMIT   = 200000;

    typedef struct packed {
        logic                     detector;
        logic [SEG_W-1:0]         segment;
        logic [EN_W-1:0]          energy;
        logic signed [TIME_W-1:0] hit_time;
        logic                     last_of_hit;
        logic                     last_of_track;
    } t_hit_sample;

    typedef struct packed {
        logic                     matched;
        logic signed [OSEG_W-1:0] best_calo;
        logic signed [OSEG_W-1:0] pion_seg;
        logic                     track_done;
    } t_match_report;

    // segment centers, x then y, 1/16 mm
    int calo_xy [48] = '{
        1800, -240, 1800, 240, 1959, 811, 1442, 1103, 1103, 1442, 811, 1959,
        240, 1800, -240, 1800, -811, 1959, -1103, 1442, -1442, 1103, -1959, 811,
        -1800, 240, -1800, -240, -1959, -811, -1442, -1103, -1103, -1442, -811, -1959,
        -240, -1800, 240, -1800, 811, -1959, 1103, -1442, 1442, -1103, 1959, -811
    };
    int pion_xy [64] = '{
        2664, -480, 2664, 0, 2664, 480, 2537, 1051, 2223, 1544, 1884, 1884,
        1544, 2223, 1051, 2537, 480, 2664, 0, 2664, -480, 2664, -1051, 2537,
        -1544, 2223, -1884, 1884, -2223, 1544, -2537, 1051, -2664, 480, -2664, 0,
        -2664, -480, -2537, -1051, -2223, -1544, -1884, -1884, -1544, -2223,
        -1051, -2537, -480, -2664, 0, -2664, 480, -2664, 1051, -2537, 1544, -2223,
        1884, -1884, 2223, -1544, 2537, -1051
    };

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic                      i_detector = 1'b0;
    logic [SEG_W-1:0]          i_segment = '0;
    logic [EN_W-1:0]           i_energy = '0;
    logic signed [TIME_W-1:0]  i_hit_time = '0;
    logic                      i_last_of_hit = 1'b0;
    logic                      i_last_of_track = 1'b0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic                      o_matched;
    logic signed [OSEG_W-1:0]  o_best_calo_segment;
    logic signed [OSEG_W-1:0]  o_pion_id_segment;
    logic                      o_track_done;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CIDX_W-1:0]         i_cfg_index = '0;
    logic [CFG_W-1:0]          i_cfg_data = '0;

    // track held by the bench, mirrors the block's registers
    bit                        trk_swap = 1'b0;
    logic signed [31:0]        trk_slope = '0;
    logic signed [31:0]        trk_icpt = '0;
    logic [31:0]               trk_norm = 32'd65536;
    logic signed [15:0]        trk_ox = '0;
    logic signed [15:0]        trk_oy = '0;
    logic signed [15:0]        trk_du = '0;
    logic signed [15:0]        trk_dv = '0;

    // running hit/track state
    bit                        hit_in_time = 1'b0;
    logic [EN_W-1:0]           top_energy = '0;
    logic signed [OSEG_W-1:0]  top_calo = SEG_NONE;
    logic signed [OSEG_W-1:0]  recent_pion = SEG_NONE;

    t_match_report             awaited_reports [$];
    t_match_report             arrived;

    int mismatch_count = 0;
    int samples_sent = 0;
    int reports_checked = 0;
    int reports_matched = 0;
    int reg_writes = 0;
    int burst_left = 4;
    int stall_mode = 0;
    int mode_left = 0;
    int cycle_count = 0;

    track_segment_matcher_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_detector          (i_detector),
        .i_segment           (i_segment),
        .i_energy            (i_energy),
        .i_hit_time          (i_hit_time),
        .i_last_of_hit       (i_last_of_hit),
        .i_last_of_track     (i_last_of_track),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_matched           (o_matched),
        .o_best_calo_segment (o_best_calo_segment),
        .o_pion_id_segment   (o_pion_id_segment),
        .o_track_done        (o_track_done),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("FAIL track_segment_matcher_unit");
            $finish;
        end
    end

    // result side stall: free-running, steady-random or mostly-stalled stretches
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(50, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= 1'($urandom_range(0, 1));
            default: i_stall <= ($urandom_range(0, 15) < 11);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_reports.size() == 0) begin
                $error("hit report with no hit pending");
                mismatch_count++;
            end else begin
                arrived = awaited_reports.pop_front();
                reports_checked++;
                if (o_matched) reports_matched++;
                if (o_matched !== arrived.matched) begin
                    $error("matched: expected %0d, got %0d", arrived.matched, o_matched);
                    mismatch_count++;
                end
                if (o_best_calo_segment !== arrived.best_calo) begin
                    $error("best_calo_segment: expected %0d, got %0d",
                           arrived.best_calo, o_best_calo_segment);
                    mismatch_count++;
                end
                if (o_pion_id_segment !== arrived.pion_seg) begin
                    $error("pion_id_segment: expected %0d, got %0d",
                           arrived.pion_seg, o_pion_id_segment);
                    mismatch_count++;
                end
                if (o_track_done !== arrived.track_done) begin
                    $error("track_done: expected %0d, got %0d",
                           arrived.track_done, o_track_done);
                    mismatch_count++;
                end
            end
        end
    end

    // forward of the track origin and within reach of the line
    function automatic bit near_track(input int x, input int y, input int reach);
        longint p, q, num, mag, dot;
        p   = trk_swap ? longint'(y) : longint'(x);
        q   = trk_swap ? longint'(x) : longint'(y);
        num = longint'(trk_slope) * p - q * 65536 + longint'(trk_icpt) * 65536;
        mag = (num < 0) ? -num : num;
        dot = longint'(trk_du) * (x - longint'(trk_ox))
            + longint'(trk_dv) * (y - longint'(trk_oy));
        if (trk_du == 0 && trk_dv == 0) return 1'b0;
        if (dot < 0) return 1'b0;
        return mag < longint'(reach) * longint'({32'd0, trk_norm});
    endfunction

    task automatic update_track_match(input t_hit_sample s);
        bit            in_time;
        bit            hit_ok;
        int            x;
        int            y;
        t_match_report rep;
        in_time = hit_in_time || (int'(s.hit_time) > -HIT_WINDOW
                                  && int'(s.hit_time) < HIT_WINDOW);
        if (!s.last_of_hit) begin
            hit_in_time = in_time;
        end else begin
            hit_in_time = 1'b0;
            hit_ok = 1'b0;
            x = 0;
            y = 0;
            if (s.detector == DET_CALO) begin
                if (s.segment < NUM_CALO) begin
                    x = calo_xy[2 * s.segment];
                    y = calo_xy[2 * s.segment + 1];
                end
                if (in_time && s.energy != 0 && near_track(x, y, CALO_REACH)) begin
                    hit_ok = 1'b1;
                    if (s.energy > top_energy) begin
                        top_energy = s.energy;
                        top_calo   = {1'b0, s.segment};
                    end
                end
            end else begin
                if (s.segment < NUM_PION) begin
                    x = pion_xy[2 * s.segment];
                    y = pion_xy[2 * s.segment + 1];
                end
                if (in_time && near_track(x, y, PION_REACH)) begin
                    hit_ok = 1'b1;
                    recent_pion = {1'b0, s.segment};
                end
            end
            rep.matched    = hit_ok;
            rep.best_calo  = top_calo;
            rep.pion_seg   = recent_pion;
            rep.track_done = s.last_of_track;
            awaited_reports.push_back(rep);
            if (s.last_of_track) begin
                top_energy  = '0;
                top_calo    = SEG_NONE;
                recent_pion = SEG_NONE;
            end
        end
    endtask

    function automatic t_hit_sample make_sample(input bit det, input int seg, input int en,
                                                input int t, input bit lh, input bit lt);
        t_hit_sample s;
        s.detector      = det;
        s.segment       = SEG_W'(seg);
        s.energy        = EN_W'(en);
        s.hit_time      = TIME_W'(t);
        s.last_of_hit   = lh;
        s.last_of_track = lt;
        return s;
    endfunction

    function automatic int window_time(input bit in_window);
        if (in_window) begin
            case ($urandom_range(0, 3))
                0: return HIT_WINDOW - 1;
                1: return 1 - HIT_WINDOW;
                default: return int'($urandom_range(0, 2 * HIT_WINDOW - 2)) - (HIT_WINDOW - 1);
            endcase
        end
        case ($urandom_range(0, 4))
            0: return HIT_WINDOW;
            1: return -HIT_WINDOW;
            2: return int'($urandom_range(HIT_WINDOW, 32767));
            3: return -int'($urandom_range(HIT_WINDOW, 32768));
            default: return (($urandom_range(0, 1) == 0) ? 32767 : -32768);
        endcase
    endfunction

    // one sample transaction; bursts of random length, random gaps between them
    task automatic send_sample(input t_hit_sample s);
        i_valid         <= 1'b1;
        i_detector      <= s.detector;
        i_segment       <= s.segment;
        i_energy        <= s.energy;
        i_hit_time      <= s.hit_time;
        i_last_of_hit   <= s.last_of_hit;
        i_last_of_track <= s.last_of_track;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        update_track_match(s);
        samples_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
        end
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_AXIS_SWAP: trk_swap  = data[0];
            REG_SLOPE:     trk_slope = data;
            REG_INTERCEPT: trk_icpt  = data;
            REG_NORM:      trk_norm  = data;
            REG_ORIGIN_X:  trk_ox    = data[15:0];
            REG_ORIGIN_Y:  trk_oy    = data[15:0];
            REG_DIR_U:     trk_du    = data[15:0];
            REG_DIR_V:     trk_dv    = data[15:0];
            default: ;
        endcase
        reg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_track(input bit swap, input logic [31:0] slope,
                              input logic [31:0] icpt, input logic [31:0] nrm,
                              input logic [15:0] ox, input logic [15:0] oy,
                              input logic [15:0] du, input logic [15:0] dv);
        write_reg(REG_AXIS_SWAP, {31'd0, swap});
        write_reg(REG_SLOPE, slope);
        write_reg(REG_INTERCEPT, icpt);
        write_reg(REG_NORM, nrm);
        write_reg(REG_ORIGIN_X, {16'd0, ox});
        write_reg(REG_ORIGIN_Y, {16'd0, oy});
        write_reg(REG_DIR_U, {16'd0, du});
        write_reg(REG_DIR_V, {16'd0, dv});
    endtask

    // hold off the sender until every pending report is in, then let the pipe empty
    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_reports.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // reset registers: zero direction, nothing can match
    task automatic test_reset_defaults();
        send_sample(make_sample(DET_CALO, 0, 65535, 0, 1'b1, 1'b0));
        send_sample(make_sample(DET_PION, 31, 0, 0, 1'b1, 1'b1));
    endtask

    // track along +x through the origin
    task automatic test_track_cuts();
        wait_idle();
        load_track(1'b0, 32'd0, 32'd0, 32'd65536, 16'd0, 16'd0, 16'd1, 16'd0);
        send_sample(make_sample(DET_CALO, 0, 100, 799, 1'b1, 1'b0));
        send_sample(make_sample(DET_CALO, 1, 100, -799, 1'b1, 1'b0));  // tie keeps best
        send_sample(make_sample(DET_CALO, 1, 0, 0, 1'b1, 1'b0));       // no energy
        send_sample(make_sample(DET_CALO, 1, 101, 800, 1'b1, 1'b0));
        send_sample(make_sample(DET_CALO, 1, 101, -800, 1'b1, 1'b0));
        // early in-time sample carries the hit
        send_sample(make_sample(DET_CALO, 1, 65535, 0, 1'b0, 1'b0));
        send_sample(make_sample(DET_CALO, 1, 101, 32767, 1'b1, 1'b0));
        // track end flag on a non-final sample is ignored; time flag was cleared
        send_sample(make_sample(DET_PION, 1, 0, -32768, 1'b0, 1'b1));
        send_sample(make_sample(DET_PION, 1, 0, 32767, 1'b1, 1'b0));
        send_sample(make_sample(DET_PION, 17, 0, 0, 1'b1, 1'b0));      // behind origin
        send_sample(make_sample(DET_PION, 0, 0, 0, 1'b1, 1'b0));
        // segments past the calorimeter count sit at the origin
        send_sample(make_sample(DET_CALO, 24, 65535, 0, 1'b1, 1'b1));
        send_sample(make_sample(DET_CALO, 31, 1, 0, 1'b1, 1'b1));
    endtask

    task automatic test_config_extremes();
        wait_idle();
        load_track(1'b0, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd1, 16'd0);
        send_sample(make_sample(DET_CALO, 0, 5, 0, 1'b1, 1'b0));
        wait_idle();
        load_track(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                   16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_sample(make_sample(DET_PION, 25, 0, 0, 1'b1, 1'b0));
        send_sample(make_sample(DET_CALO, 20, 7, 0, 1'b1, 1'b0));
        wait_idle();
        load_track(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                   16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_sample(make_sample(DET_PION, 8, 0, 0, 1'b1, 1'b0));
        send_sample(make_sample(DET_CALO, 7, 9, 0, 1'b1, 1'b1));
        wait_idle();
        // huge norm: anything forward is near
        load_track(1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd1, 16'd0);
        send_sample(make_sample(DET_PION, 9, 0, 0, 1'b1, 1'b1));
    endtask

    task automatic test_random_tracks();
        int  phase, phase_samples, aim_det, aim_seg, tx, ty, ox, oy, dx, dy, scale;
        int  slope, icpt, n, in_slot, seg, det, en, i;
        bit  want_time, close, paused;
        real s;
        paused = 1'b0;
        for (phase = 0; phase < 8; phase++) begin
            wait_idle();
            aim_det = $urandom_range(0, 1);
            aim_seg = aim_det ? $urandom_range(0, NUM_PION - 1)
                              : $urandom_range(0, NUM_CALO - 1);
            if ($urandom_range(0, 7) < 6) begin
                // line from a point near the origin toward a chosen segment
                tx = (aim_det ? pion_xy[2 * aim_seg] : calo_xy[2 * aim_seg])
                     + int'($urandom_range(0, 600)) - 300;
                ty = (aim_det ? pion_xy[2 * aim_seg + 1] : calo_xy[2 * aim_seg + 1])
                     + int'($urandom_range(0, 600)) - 300;
                ox = int'($urandom_range(0, 400)) - 200;
                oy = int'($urandom_range(0, 400)) - 200;
                dx = tx - ox;
                dy = ty - oy;
                if ((dx < 0 ? -dx : dx) >= (dy < 0 ? -dy : dy)) begin
                    slope = (dy * 65536) / dx;
                    icpt  = oy - (slope * ox) / 65536;
                end else begin
                    slope = (dx * 65536) / dy;
                    icpt  = ox - (slope * oy) / 65536;
                end
                s = real'(slope) / 65536.0;
                scale = $urandom_range(1, 8);
                if ($urandom_range(0, 7) == 0) scale = -scale;    // pointing away
                load_track((dx < 0 ? -dx : dx) < (dy < 0 ? -dy : dy), slope, icpt,
                           int'($sqrt(1.0 + s * s) * 65536.0), 16'(ox), 16'(oy),
                           16'(dx * scale), 16'(dy * scale));
            end else begin
                load_track(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            end
            phase_samples = 0;
            while (phase_samples < 62) begin
                if (phase == 3 && !paused && phase_samples >= 30) begin
                    wait_idle();
                    paused = 1'b1;
                end
                det = ($urandom_range(0, 1) == 0) ? aim_det : $urandom_range(0, 1);
                if (det == aim_det && $urandom_range(0, 4) < 3) begin
                    seg = aim_seg + int'($urandom_range(0, 2)) - 1;
                    if (seg < 0) seg = det ? NUM_PION - 1 : NUM_CALO - 1;
                    if (seg >= (det ? NUM_PION : NUM_CALO)) seg = 0;
                end else begin
                    seg = $urandom_range(0, 31);
                end
                case ($urandom_range(0, 7))
                    0: en = 0;
                    1, 2: en = $urandom_range(1, 4);
                    default: en = $urandom_range(1, 65535);
                endcase
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 4) : $urandom_range(1, 2);
                want_time = ($urandom_range(0, 9) < 8);
                in_slot = $urandom_range(0, n - 1);
                close = ($urandom_range(0, 5) == 0);
                for (i = 0; i < n; i++) begin
                    send_sample(make_sample(1'(det), seg,
                        (i == n - 1) ? en : int'($urandom_range(0, 65535)),
                        (want_time && i == in_slot) ? window_time(1'b1)
                            : (want_time ? int'($urandom_range(0, 65535)) - 32768
                                         : window_time(1'b0)),
                        i == n - 1,
                        (i == n - 1) ? close : ($urandom_range(0, 7) == 0)));
                end
                phase_samples += n;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_track_cuts();
        test_config_extremes();
        test_random_tracks();
        wait_idle();
        $display("Sent %0d hit samples with %0d register writes over directed and random tracks.",
                 samples_sent, reg_writes);
        $display("Checked %0d hit reports, %0d of them matched.", reports_checked,
                 reports_matched);
        if (mismatch_count == 0) begin
            $display("PASS track_segment_matcher_unit");
        end else begin
            $display("FAIL track_segment_matcher_unit");
        end
        $finish;
    end

endmodule
